/* rtl/nalsp_pkg.sv */
// Shared types for the Annex B NAL unit splitter.
`default_nettype none

package nalsp_pkg;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        unit_first;
        logic        unit_last;
        logic        unit_empty;
        logic [4:0]  unit_kind;
        logic [31:0] unit_time;
        logic        run_last;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

endpackage

`default_nettype wire

/* rtl/nalsp_front.sv */
// Front end: byte window, start code detection and unit framing decisions.
`default_nettype none

module nalsp_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_stall,
    input  wire logic [7:0]          in_byte,
    input  wire logic                frame_end,
    input  wire logic signed [31:0]  frame_time,
    output nalsp_pkg::push_t         push,
    input  wire logic                q_full
);
    import nalsp_pkg::*;

    localparam int          WIN       = 6;
    localparam logic [4:0]  KIND_SPS  = 5'h07;
    localparam logic [4:0]  KIND_PPS  = 5'h08;
    localparam logic [7:0]  BYTE_ZERO = 8'h00;
    localparam logic [7:0]  BYTE_ONE  = 8'h01;

    typedef logic [WIN-1:0][7:0] win_t;

    // Start code length at position p of w[0..n-1], zero if none.
    function automatic logic [2:0] code_len(input win_t w, input logic [2:0] n,
                                            input logic [1:0] p, input logic [4:0] kind);
        logic [2:0] b;
        logic [3:0] nn;
        logic       z0;
        logic       z1;
        logic       z2;
        logic       o2;
        logic       o3;
        b  = {1'b0, p};
        nn = {1'b0, n};
        z0 = (w[b] == BYTE_ZERO);
        z1 = (w[b + 3'd1] == BYTE_ZERO);
        z2 = (w[b + 3'd2] == BYTE_ZERO);
        o2 = (w[b + 3'd2] == BYTE_ONE);
        o3 = (w[b + 3'd3] == BYTE_ONE);
        code_len = 3'd0;
        if ((kind == KIND_SPS || kind == KIND_PPS) && (({1'b0, b} + 4'd3) < nn)
            && z0 && z1 && o2)
        begin
            code_len = 3'd3;
        end
        else if ((({1'b0, b} + 4'd4) < nn) && z0 && z1 && z2 && o3)
        begin
            code_len = 3'd4;
        end
    endfunction

    win_t        win_reg,    win_next;
    logic [2:0]  cnt_reg,    cnt_next;
    logic        inside_reg, inside_next;
    logic        pend_reg,   pend_next;
    logic [4:0]  ckind_reg,  ckind_next;
    logic [4:0]  lkind_reg,  lkind_next;
    logic        start_reg,  start_next;
    logic        flush_reg,  flush_next;
    logic [31:0] time_reg,   time_next;

    logic        accept;
    logic        run;
    win_t        w;
    win_t        w_sh;
    logic [2:0]  n;
    logic [2:0]  n_sh;
    logic        e;
    logic [31:0] t;
    logic [4:0]  lk;
    logic [2:0]  len0;
    logic [2:0]  len1;
    logic [2:0]  shift;
    logic [3:0]  idx;
    logic        ins_a;
    logic        pend_a;
    logic [4:0]  ck_a;
    logic        more;
    entry_t      res;
    logic        res_valid;

    assign byte_stall = flush_reg || q_full;
    assign accept     = byte_valid && !byte_stall;
    assign run        = accept || (flush_reg && !q_full);

    always_comb
    begin
        if (flush_reg)
        begin
            w = win_reg;
            n = cnt_reg;
            e = 1'b1;
            t = time_reg;
        end
        else
        begin
            for (int i = 0; i < WIN; i++)
            begin
                w[i] = (3'(i) == cnt_reg) ? in_byte : win_reg[i];
            end
            n = cnt_reg + 3'd1;
            e = frame_end;
            t = $unsigned(frame_time);
        end
        lk = (!flush_reg && start_reg) ? in_byte[4:0] : lkind_reg;

        shift     = 3'd0;
        ins_a     = inside_reg;
        pend_a    = pend_reg;
        ck_a      = ckind_reg;
        res_valid = 1'b0;
        res       = '0;
        res.unit_kind = ckind_reg;
        res.unit_time = t;
        len0      = 3'd0;
        len1      = 3'd0;

        if (e || n >= 3'd5)
        begin
            if (!inside_reg)
            begin
                len0 = code_len(w, n, 2'd0, lk);
                if (len0 != 3'd0)
                begin
                    shift  = len0;
                    ins_a  = 1'b1;
                    pend_a = 1'b1;
                    ck_a   = w[len0][4:0];
                end
                else
                begin
                    shift = 3'd1;
                end
            end
            else
            begin
                len0 = code_len(w, n, 2'd0, ckind_reg);
                if (len0 != 3'd0)
                begin
                    // back-to-back codes: zero-length unit marker
                    if (pend_reg)
                    begin
                        res_valid       = 1'b1;
                        res.unit_first  = 1'b1;
                        res.unit_last   = 1'b1;
                        res.unit_empty  = 1'b1;
                    end
                    shift  = len0;
                    pend_a = 1'b1;
                    ck_a   = w[len0][4:0];
                end
                else if (e || n == 3'd6)
                begin
                    len1           = code_len(w, n, 2'd1, ckind_reg);
                    res_valid      = 1'b1;
                    res.out_byte   = w[0];
                    res.unit_first = pend_reg;
                    res.unit_last  = (n == 3'd1) || (len1 != 3'd0);
                    if (len1 != 3'd0)
                    begin
                        shift  = len1 + 3'd1;
                        pend_a = 1'b1;
                        ck_a   = w[len1 + 3'd1][4:0];
                    end
                    else
                    begin
                        shift  = 3'd1;
                        pend_a = 1'b0;
                    end
                end
            end
        end

        for (int i = 0; i < WIN; i++)
        begin
            idx     = 4'(i) + {1'b0, shift};
            w_sh[i] = (idx < 4'(WIN)) ? w[idx[2:0]] : BYTE_ZERO;
        end
        n_sh = n - shift;

        if (ins_a)
        begin
            more = (n_sh != 3'd0);
        end
        else
        begin
            more = (code_len(w_sh, n_sh, 2'd0, lk) != 3'd0)
                || (code_len(w_sh, n_sh, 2'd1, lk) != 3'd0)
                || (code_len(w_sh, n_sh, 2'd2, lk) != 3'd0);
        end
        res.run_last = !e || !more;

        win_next    = win_reg;
        cnt_next    = cnt_reg;
        inside_next = inside_reg;
        pend_next   = pend_reg;
        ckind_next  = ckind_reg;
        lkind_next  = lkind_reg;
        start_next  = start_reg;
        flush_next  = flush_reg;
        time_next   = time_reg;

        if (run)
        begin
            win_next    = w_sh;
            cnt_next    = n_sh;
            inside_next = ins_a;
            pend_next   = pend_a;
            ckind_next  = ck_a;
            lkind_next  = lk;
            start_next  = 1'b0;
            time_next   = t;
            if (e && n_sh == 3'd0)
            begin
                inside_next = 1'b0;
                pend_next   = 1'b0;
                start_next  = 1'b1;
                flush_next  = 1'b0;
            end
            else
            begin
                flush_next = e;
            end
        end

        push.valid = run && res_valid;
        push.entry = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= '0;
            cnt_reg    <= 3'd0;
            inside_reg <= 1'b0;
            pend_reg   <= 1'b0;
            ckind_reg  <= 5'd0;
            lkind_reg  <= 5'd0;
            start_reg  <= 1'b1;
            flush_reg  <= 1'b0;
            time_reg   <= 32'd0;
        end
        else
        begin
            win_reg    <= win_next;
            cnt_reg    <= cnt_next;
            inside_reg <= inside_next;
            pend_reg   <= pend_next;
            ckind_reg  <= ckind_next;
            lkind_reg  <= lkind_next;
            start_reg  <= start_next;
            flush_reg  <= flush_next;
            time_reg   <= time_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/nalsp_back.sv */
// Back end: result queue whose head drives the output channel.
`default_nettype none

module nalsp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nalsp_pkg::push_t   push,
    output logic                    q_full,
    output logic                    unit_valid,
    input  wire logic               unit_stall,
    output nalsp_pkg::entry_t       head
);
    import nalsp_pkg::*;

    localparam int QDEPTH = 4;
    localparam int PW     = $clog2(QDEPTH);

    entry_t          q_reg [QDEPTH];
    logic [PW-1:0]   wr_reg,  wr_next;
    logic [PW-1:0]   rd_reg,  rd_next;
    logic [PW:0]     cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign q_full     = (cnt_reg == (PW + 1)'(QDEPTH));
    assign unit_valid = (cnt_reg != '0);
    assign head       = q_reg[rd_reg];
    assign do_push    = push.valid && !q_full;
    assign do_pop     = unit_valid && !unit_stall;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/annexb_nal_unit_splitter_top.sv */
// Top level of the Annex B NAL unit splitter.
`default_nettype none

// Splits the bytes of an encoded frame into NAL units at Annex B start codes and
// emits one payload byte per result, tagged with first/last/empty, the unit kind,
// the frame time and the last result of the input byte that caused it. Input bytes
// are taken one per cycle while byte_stall is low, each making at most one window
// decision. A byte flagged frame_end is followed by a flush with byte_stall high,
// resolving the six-byte window one decision per cycle unless the queue is full.
// Results leave at most one per cycle from a four-entry queue. Any cycle that starts
// with the queue full holds byte_stall high and pauses the flush, so output stalls
// reach the input only once four results are waiting.

module annexb_nal_unit_splitter_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_stall,
    input  wire logic [7:0]         in_byte,
    input  wire logic               frame_end,
    input  wire logic signed [31:0] frame_time,
    output logic                    unit_valid,
    input  wire logic               unit_stall,
    output logic [7:0]              out_byte,
    output logic                    unit_first,
    output logic                    unit_last,
    output logic                    unit_empty,
    output logic [4:0]              unit_kind,
    output logic signed [31:0]      unit_time,
    output logic                    run_last
);
    import nalsp_pkg::*;

    push_t  push;
    logic   q_full;
    entry_t head;

    nalsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .in_byte    (in_byte),
        .frame_end  (frame_end),
        .frame_time (frame_time),
        .push       (push),
        .q_full     (q_full)
    );

    nalsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .q_full     (q_full),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .head       (head)
    );

    assign out_byte   = head.out_byte;
    assign unit_first = head.unit_first;
    assign unit_last  = head.unit_last;
    assign unit_empty = head.unit_empty;
    assign unit_kind  = head.unit_kind;
    assign unit_time  = $signed(head.unit_time);
    assign run_last   = head.run_last;

endmodule

`default_nettype wire
